>>> hdl/tbfl_pkg.sv
// shared constants, types and codes of the tiered block free list
package tbfl_pkg;

    localparam int HOT_DEPTH   = 64;
    localparam int WARM_DEPTH  = 128;
    localparam int BLOCK_COUNT = 256;

    localparam int HOT_AW     = (HOT_DEPTH > 1) ? $clog2(HOT_DEPTH) : 1;
    localparam int WARM_AW    = (WARM_DEPTH > 1) ? $clog2(WARM_DEPTH) : 1;
    localparam int BLK_AW     = $clog2(BLOCK_COUNT);
    localparam int HOT_CNT_W  = $clog2(HOT_DEPTH + 1);
    localparam int WARM_CNT_W = $clog2(WARM_DEPTH + 1);
    localparam int LIST_CNT_W = $clog2(BLOCK_COUNT + 1);

    // field widths of the ports
    localparam int HANDLE_W     = 8;
    localparam int HOT_LIM_W    = 7;
    localparam int WARM_LIM_W   = 8;
    localparam int LIST_FILL_W  = 9;
    localparam int CFG_DATA_W   = 8;
    localparam int OUT_DATA_W   = 40;

    localparam logic [0:0] CFG_HOT_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_WARM_LIMIT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        TIER_HOT  = 2'd0,
        TIER_WARM = 2'd1,
        TIER_LIST = 2'd2,
        TIER_NONE = 2'd3
    } tier_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

>>> hdl/tbfl_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module tbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/tiered_block_free_list.sv
// top level of the tiered block free list allocator
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser operation, tdata block_handle
// m_*       out  m_tvalid/m_tready  tdata result word
// cfg_*     in   cfg_we             cfg_index, cfg_wdata
//
// each word is handled as a read of the three tier memories (hot stack top,
// warm stack top, link of the list head), then the decision and write-back
// reset leaves the stacks empty and the free list full, highest block at the head;
// links of entries never written read as the index below, so no clearing pass
// a result waits in the output register while the next word is taken in; the
// decision cycle holds until that register is free
module tiered_block_free_list
    import tbfl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [HANDLE_W-1:0]    s_tdata,   // block_handle
    input  logic [0:0]             s_tuser,   // operation
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // success, granted_handle, tier, hot_fill, warm_fill, list_free_count, zero pad
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [0:0]             cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    state_t state_reg, state_next;

    logic [HOT_LIM_W-1:0]  hot_limit_reg;
    logic [WARM_LIM_W-1:0] warm_limit_reg;

    logic [HOT_CNT_W-1:0]  hot_count_reg, hot_count_next;
    logic [WARM_CNT_W-1:0] warm_count_reg, warm_count_next;
    logic [BLK_AW-1:0]     list_head_reg, list_head_next;
    logic [LIST_CNT_W-1:0] list_count_reg, list_count_next;
    logic [BLOCK_COUNT-1:0] link_valid_reg;

    logic                  op_reg;
    logic [HANDLE_W-1:0]   handle_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic accept;
    logic commit;

    // memory ports
    logic [HOT_AW-1:0]  hot_raddr, hot_waddr;
    logic [WARM_AW-1:0] warm_raddr, warm_waddr;
    logic [BLK_AW-1:0]  hot_rdata, warm_rdata, link_rdata;
    logic               hot_we, warm_we, link_we;

    // decision results
    logic              ok;
    tier_t             tier;
    logic [BLK_AW-1:0] granted;
    logic [HOT_CNT_W-1:0]  hot_cap;
    logic [WARM_CNT_W-1:0] warm_cap;
    logic [BLK_AW-1:0] head_link;
    logic [BLK_AW-1:0] free_handle;
    logic              handle_ok;

    tbfl_ram #(.WIDTH(BLK_AW), .DEPTH(HOT_DEPTH)) u_hot_ram (
        .clk   (clk),
        .we    (hot_we),
        .waddr (hot_waddr),
        .wdata (free_handle),
        .re    (accept),
        .raddr (hot_raddr),
        .rdata (hot_rdata)
    );

    tbfl_ram #(.WIDTH(BLK_AW), .DEPTH(WARM_DEPTH)) u_warm_ram (
        .clk   (clk),
        .we    (warm_we),
        .waddr (warm_waddr),
        .wdata (free_handle),
        .re    (accept),
        .raddr (warm_raddr),
        .rdata (warm_rdata)
    );

    tbfl_ram #(.WIDTH(BLK_AW), .DEPTH(BLOCK_COUNT)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (free_handle),
        .wdata (list_head_reg),
        .re    (accept),
        .raddr (list_head_reg),
        .rdata (link_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        s_tready = 1'b0;
        commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_EXEC:
            begin
                commit = !m_tvalid_reg || m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // top-of-stack reads; garbage when a stack is empty, never used then
    assign hot_raddr  = HOT_AW'(hot_count_reg - 1'b1);
    assign warm_raddr = WARM_AW'(warm_count_reg - 1'b1);
    assign hot_waddr  = HOT_AW'(hot_count_reg);
    assign warm_waddr = WARM_AW'(warm_count_reg);

    // limits above the stack depth act as the depth
    assign hot_cap  = (32'(hot_limit_reg) > HOT_DEPTH) ? HOT_CNT_W'(HOT_DEPTH)
                                                      : HOT_CNT_W'(hot_limit_reg);
    assign warm_cap = (32'(warm_limit_reg) > WARM_DEPTH) ? WARM_CNT_W'(WARM_DEPTH)
                                                        : WARM_CNT_W'(warm_limit_reg);

    // an untouched link points at the index below, block zero at itself
    assign head_link = link_valid_reg[list_head_reg] ? link_rdata :
                       (list_head_reg == '0) ? '0 : list_head_reg - 1'b1;

    assign free_handle = BLK_AW'(handle_reg);
    assign handle_ok   = 32'(handle_reg) < BLOCK_COUNT;

    // tier decision
    always_comb
    begin
        ok              = 1'b0;
        tier            = TIER_NONE;
        granted         = '0;
        hot_we          = 1'b0;
        warm_we         = 1'b0;
        link_we         = 1'b0;
        hot_count_next  = hot_count_reg;
        warm_count_next = warm_count_reg;
        list_head_next  = list_head_reg;
        list_count_next = list_count_reg;
        if (op_reg == OP_ALLOC)
        begin
            if (hot_count_reg != '0)
            begin
                ok             = 1'b1;
                tier           = TIER_HOT;
                granted        = hot_rdata;
                hot_count_next = hot_count_reg - 1'b1;
            end
            else if (warm_count_reg != '0)
            begin
                ok              = 1'b1;
                tier            = TIER_WARM;
                granted         = warm_rdata;
                warm_count_next = warm_count_reg - 1'b1;
            end
            else if (list_count_reg != '0)
            begin
                ok              = 1'b1;
                tier            = TIER_LIST;
                granted         = list_head_reg;
                list_head_next  = head_link;
                list_count_next = list_count_reg - 1'b1;
            end
        end
        else if (handle_ok)
        begin
            if (hot_count_reg < hot_cap)
            begin
                ok             = 1'b1;
                tier           = TIER_HOT;
                hot_we         = commit;
                hot_count_next = hot_count_reg + 1'b1;
            end
            else if (warm_count_reg < warm_cap)
            begin
                ok              = 1'b1;
                tier            = TIER_WARM;
                warm_we         = commit;
                warm_count_next = warm_count_reg + 1'b1;
            end
            else if (32'(list_count_reg) < BLOCK_COUNT)
            begin
                ok              = 1'b1;
                tier            = TIER_LIST;
                link_we         = commit;
                list_head_next  = free_handle;
                list_count_next = list_count_reg + 1'b1;
            end
        end
    end

    // result word and output register
    always_comb
    begin
        m_data_next = m_data_reg;
        if (commit)
        begin
            m_data_next = {5'b0,
                           LIST_FILL_W'(list_count_next),
                           WARM_LIM_W'(warm_count_next),
                           HOT_LIM_W'(hot_count_next),
                           tier,
                           HANDLE_W'(granted),
                           ok};
        end
    end

    always_comb
    begin
        if (commit)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            hot_count_reg  <= '0;
            warm_count_reg <= '0;
            list_head_reg  <= BLK_AW'(BLOCK_COUNT - 1);
            list_count_reg <= LIST_CNT_W'(BLOCK_COUNT);
            link_valid_reg <= '0;
            hot_limit_reg  <= HOT_LIM_W'(64);
            warm_limit_reg <= WARM_LIM_W'(128);
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (commit)
            begin
                hot_count_reg  <= hot_count_next;
                warm_count_reg <= warm_count_next;
                list_head_reg  <= list_head_next;
                list_count_reg <= list_count_next;
            end
            if (link_we)
            begin
                link_valid_reg[free_handle] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HOT_LIMIT:  hot_limit_reg  <= HOT_LIM_W'(cfg_wdata);
                    CFG_WARM_LIMIT: warm_limit_reg <= WARM_LIM_W'(cfg_wdata);
                    default:        hot_limit_reg  <= hot_limit_reg;
                endcase
            end
        end
    end

    // request payload, captured on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_tuser[0];
            handle_reg <= s_tdata;
        end
        m_data_reg <= m_data_next;
    end

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the tiered block free list allocator
module tb_top;
    import tbfl_pkg::*;

    // one predicted result word, field by field
    typedef struct {
        logic                   success;
        logic [HANDLE_W-1:0]    handle;
        tier_t                  tier;
        logic [HOT_LIM_W-1:0]   hot_fill;
        logic [WARM_LIM_W-1:0]  warm_fill;
        logic [LIST_FILL_W-1:0] list_fill;
    } alloc_result_t;

    // shadow of the allocator: both stacks, the linked list and the limits,
    // plus the queue of result words still owed by the block
    class free_list_tracker;
        logic [HANDLE_W-1:0] hot_mem[HOT_DEPTH];
        logic [HANDLE_W-1:0] warm_mem[WARM_DEPTH];
        int                  link[BLOCK_COUNT];
        int                  hot_cnt;
        int                  warm_cnt;
        int                  head;
        int                  list_cnt;
        int                  hot_lim;
        int                  warm_lim;
        alloc_result_t       pending[$];
        int                  held[$];
        int                  mismatches;
        int                  strays;
        int                  allocs;
        int                  frees;
        int                  tier_seen[4];

        function new();
            int i;
            hot_lim  = 64;
            warm_lim = 128;
            hot_cnt  = 0;
            warm_cnt = 0;
            for (i = 0; i < BLOCK_COUNT; i++)
                link[i] = (i == 0) ? 0 : i - 1;
            head       = BLOCK_COUNT - 1;
            list_cnt   = BLOCK_COUNT;
            mismatches = 0;
            strays     = 0;
            allocs     = 0;
            frees      = 0;
            for (i = 0; i < 4; i++)
                tier_seen[i] = 0;
        endfunction

        function void set_limit(logic [0:0] idx, int value);
            if (idx == CFG_HOT_LIMIT)
                hot_lim = value & 'h7F;
            else
                warm_lim = value & 'hFF;
        endfunction

        // work out the result of one accepted request word and queue it
        function void note_request(logic op, int h);
            alloc_result_t r;
            int            hl;
            int            wl;
            r.success = 1'b0;
            r.handle  = '0;
            r.tier    = TIER_NONE;
            hl = (hot_lim > HOT_DEPTH) ? HOT_DEPTH : hot_lim;
            wl = (warm_lim > WARM_DEPTH) ? WARM_DEPTH : warm_lim;
            if (op == OP_ALLOC)
            begin
                allocs++;
                if (hot_cnt > 0)
                begin
                    hot_cnt--;
                    r.handle  = hot_mem[hot_cnt];
                    r.success = 1'b1;
                    r.tier    = TIER_HOT;
                end
                else if (warm_cnt > 0)
                begin
                    warm_cnt--;
                    r.handle  = warm_mem[warm_cnt];
                    r.success = 1'b1;
                    r.tier    = TIER_WARM;
                end
                else if (list_cnt > 0)
                begin
                    r.handle  = HANDLE_W'(head);
                    head      = link[head];
                    list_cnt--;
                    r.success = 1'b1;
                    r.tier    = TIER_LIST;
                end
                if (r.success)
                    held.push_back(int'(r.handle));
            end
            else
            begin
                frees++;
                if (h < BLOCK_COUNT)
                begin
                    if (hot_cnt < hl)
                    begin
                        hot_mem[hot_cnt] = HANDLE_W'(h);
                        hot_cnt++;
                        r.success = 1'b1;
                        r.tier    = TIER_HOT;
                    end
                    else if (warm_cnt < wl)
                    begin
                        warm_mem[warm_cnt] = HANDLE_W'(h);
                        warm_cnt++;
                        r.success = 1'b1;
                        r.tier    = TIER_WARM;
                    end
                    else if (list_cnt < BLOCK_COUNT)
                    begin
                        link[h] = head;
                        head    = h;
                        list_cnt++;
                        r.success = 1'b1;
                        r.tier    = TIER_LIST;
                    end
                end
            end
            r.hot_fill  = HOT_LIM_W'(hot_cnt);
            r.warm_fill = WARM_LIM_W'(warm_cnt);
            r.list_fill = LIST_FILL_W'(list_cnt);
            pending.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        // result word layout from bit 0: success, granted_handle, tier,
        // hot_fill, warm_fill, list_free_count
        function void check_result(logic [OUT_DATA_W-1:0] d);
            alloc_result_t r;
            if (pending.size() == 0)
            begin
                $error("result word %h with no request outstanding", d);
                strays++;
                return;
            end
            r = pending.pop_front();
            tier_seen[int'(r.tier)]++;
            compare_field("success", 32'(r.success), 32'(d[0]));
            compare_field("granted_handle", 32'(r.handle), 32'(d[8:1]));
            compare_field("tier", 32'(r.tier), 32'(d[10:9]));
            compare_field("hot_fill", 32'(r.hot_fill), 32'(d[17:11]));
            compare_field("warm_fill", 32'(r.warm_fill), 32'(d[25:18]));
            compare_field("list_free_count", 32'(r.list_fill), 32'(d[34:26]));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [HANDLE_W-1:0]   s_tdata = '0;    // block_handle
    logic [0:0]            s_tuser = '0;    // operation
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // success, granted_handle, tier, hot_fill, warm_fill, list_free_count, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [0:0]            cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    free_list_tracker tracker;
    int               burst_left = 0;
    int               settings = 0;
    int               stall_mode = 0;
    int               stall_span = 0;

    tiered_block_free_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // receiver back-pressure: spans of always ready, coin-toss ready and
    // mostly stalled, each span of random length
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_span <= $urandom_range(16, 96);
        end
        else
            stall_span <= stall_span - 1;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // result monitor: every accepted word is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // hand one request word over; the sender runs in bursts with idle gaps
    // between them, and the word is predicted at the edge it is taken
    task automatic send_word(logic op, logic [HANDLE_W-1:0] h);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= h;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tracker.note_request(op, int'(h));
        burst_left--;
    endtask

    // stop sending and wait for every owed result word
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
    endtask

    // both limits are rewritten one after the other, only once the block is idle
    task automatic set_limits(int hot, int warm);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_HOT_LIMIT;
        cfg_wdata <= CFG_DATA_W'(hot);
        tracker.set_limit(CFG_HOT_LIMIT, hot);
        @(posedge clk);
        cfg_index <= CFG_WARM_LIMIT;
        cfg_wdata <= CFG_DATA_W'(warm);
        tracker.set_limit(CFG_WARM_LIMIT, warm);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        int                  sent;
        int                  phase;
        int                  span;
        int                  alloc_pct;
        int                  hot;
        int                  warm;
        int                  idx;
        logic                op;
        logic [HANDLE_W-1:0] h;

        tracker = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits: two from the list head, then frees into the hot
        // stack at the handle extremes, a double free, and pops back out
        send_word(OP_ALLOC, 8'h00);
        send_word(OP_ALLOC, 8'hFF);
        send_word(OP_FREE, 8'h00);
        send_word(OP_FREE, 8'hFF);
        send_word(OP_FREE, 8'hAA);
        send_word(OP_FREE, 8'h55);
        send_word(OP_FREE, 8'h55);
        send_word(OP_ALLOC, 8'h5A);
        send_word(OP_ALLOC, 8'hA5);
        send_word(OP_ALLOC, 8'h00);

        // both limits zero while the hot stack still holds entries: frees
        // spill to the list until it is full and then get refused, yet
        // allocates still pop the hot stack
        set_limits(0, 0);
        send_word(OP_FREE, 8'h01);
        send_word(OP_FREE, 8'h02);
        send_word(OP_FREE, 8'h03);
        send_word(OP_ALLOC, 8'hFF);
        send_word(OP_FREE, 8'h80);

        // limits above the stack depths act as the depths
        set_limits(127, 255);
        send_word(OP_FREE, 8'h7F);
        send_word(OP_FREE, 8'hFE);
        send_word(OP_ALLOC, 8'h00);
        send_word(OP_ALLOC, 8'h00);
        set_limits(0, 1);
        send_word(OP_FREE, 8'h11);
        send_word(OP_FREE, 8'h22);
        send_word(OP_ALLOC, 8'h00);
        send_word(OP_ALLOC, 8'h00);

        // random phases: first drain the list dry so allocates find nothing,
        // then refill the stacks, then overfill the list, then mixed traffic
        sent  = 0;
        phase = 0;
        while (sent < 1100)
        begin
            case (phase)
                0:
                begin
                    set_limits(HOT_DEPTH, WARM_DEPTH);
                    alloc_pct = 95;
                    span      = 330;
                end
                1:
                begin
                    set_limits(127, 255);
                    alloc_pct = 5;
                    span      = 150;
                end
                2:
                begin
                    set_limits(0, 0);
                    alloc_pct = 10;
                    span      = 120;
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       hot = 0;
                        1:       hot = HOT_DEPTH;
                        2:       hot = 127;
                        default: hot = $urandom_range(0, 127);
                    endcase
                    case ($urandom_range(0, 4))
                        0:       warm = 0;
                        1:       warm = WARM_DEPTH;
                        2:       warm = 255;
                        default: warm = $urandom_range(0, 255);
                    endcase
                    set_limits(hot, warm);
                    alloc_pct = $urandom_range(10, 90);
                    span      = $urandom_range(60, 160);
                end
            endcase
            for (int k = 0; k < span && sent < 1100; k++)
            begin
                op = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOC : OP_FREE;
                // frees mostly give back a handle that was handed out,
                // now and then any handle at all
                if (op == OP_FREE && tracker.held.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    idx = $urandom_range(0, tracker.held.size() - 1);
                    h   = HANDLE_W'(tracker.held[idx]);
                    tracker.held.delete(idx);
                end
                else
                    h = HANDLE_W'($urandom_range(0, 255));
                if ($urandom_range(0, 149) == 0)
                    drain();
                send_word(op, h);
                sent++;
            end
            phase++;
        end

        drain();
        repeat (10) @(posedge clk);

        $display("run covered %0d allocates and %0d frees under %0d limit settings",
                 tracker.allocs, tracker.frees, settings);
        $display("results by tier: hot %0d, warm %0d, list %0d, none %0d",
                 tracker.tier_seen[0], tracker.tier_seen[1],
                 tracker.tier_seen[2], tracker.tier_seen[3]);
        if (tracker.mismatches == 0 && tracker.strays == 0 && tracker.pending.size() == 0)
            $display("** tiered_block_free_list: PASSED **");
        else
            $display("** tiered_block_free_list: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #(8 * 400000);
        $display("** tiered_block_free_list: FAILED **");
        $finish;
    end

endmodule
